@@ rtl/pti_pkg.sv @@
package pti_pkg;

  localparam int unsigned MAX_LEN_DEF  = 4096;
  localparam int unsigned ALPHABET_DEF = 26;

  // Fixed field widths of the stream payload.
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned FIELD_W    = 13;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

endpackage

@@ rtl/pti_node_mem.sv @@
module pti_node_mem #(
  parameter int unsigned NW = 13,
  parameter int unsigned LW = 13
) (
  input  logic                     clk_i,
  input  logic [NW-1:0]            rd_addr_i,
  output logic signed [LW:0]       rd_len_o,
  output logic [NW-1:0]            rd_link_o,
  output logic [LW-1:0]            rd_scnt_o,
  output logic [LW-1:0]            rd_occ_o,
  output logic [NW-1:0]            rd_parent_o,
  output logic [pti_pkg::SYM_W-1:0] rd_sym_o,
  input  logic                     wr_en_i,
  input  logic [NW-1:0]            wr_addr_i,
  input  logic [LW-1:0]            wr_len_i,
  input  logic [NW-1:0]            wr_link_i,
  input  logic [LW-1:0]            wr_scnt_i,
  input  logic [LW-1:0]            wr_occ_i,
  input  logic [NW-1:0]            wr_parent_i,
  input  logic [pti_pkg::SYM_W-1:0] wr_sym_i
);
  import pti_pkg::*;

  localparam int unsigned RW = 3 * LW + 2 * NW + SYM_W;

  logic [RW-1:0] mem [2**NW];
  logic [RW-1:0] rd_q;
  logic [NW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_len_i, wr_link_i, wr_scnt_i, wr_occ_i, wr_parent_i, wr_sym_i};
    end
    rd_q   <= mem[rd_addr_i];
    addr_q <= rd_addr_i;
  end

  // The two roots are constants and never live in the array.
  always_comb begin
    {rd_parent_o, rd_sym_o} = rd_q[NW+SYM_W-1:0];
    rd_occ_o  = rd_q[NW+SYM_W +: LW];
    rd_scnt_o = rd_q[NW+SYM_W+LW +: LW];
    rd_link_o = rd_q[NW+SYM_W+2*LW +: NW];
    rd_len_o  = $signed({1'b0, rd_q[2*NW+SYM_W+2*LW +: LW]});
    if (addr_q == NW'(0)) begin
      rd_len_o  = '0;
      rd_link_o = NW'(1);
      rd_scnt_o = '0;
      rd_occ_o  = '0;
    end else if (addr_q == NW'(1)) begin
      rd_len_o  = '1;
      rd_link_o = '0;
      rd_scnt_o = '0;
      rd_occ_o  = '0;
    end
  end

endmodule

@@ rtl/pti_edge_mem.sv @@
module pti_edge_mem #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26,
  parameter int unsigned NW       = 13
) (
  input  logic                      clk_i,
  input  logic [NW-1:0]             node_i,
  input  logic [pti_pkg::SYM_W-1:0] sym_i,
  input  logic                      wr_en_i,
  input  logic [NW-1:0]             wr_data_i,
  output logic [NW-1:0]             rd_data_o
);
  import pti_pkg::*;

  localparam int unsigned DEPTH = (MAX_LEN + 2) * ALPHABET;
  localparam int unsigned AW    = $clog2(DEPTH);

  bit   [NW-1:0] mem [DEPTH];
  logic [AW-1:0] addr;

  // Row of a node, column of a symbol.
  assign addr = AW'(AW'(node_i) * AW'(ALPHABET)) + AW'(sym_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr] <= wr_data_i;
    end
    rd_data_o <= mem[addr];
  end

endmodule

@@ rtl/palindromic_tree_insert_core.sv @@
// Flow: a symbol walks suffix links from the last node, reading a node, then its mirror text;
// a hop over the sentinel and a stop on the odd root skip the text read. It then reads and
// checks the edge. A new node adds a second walk from the parent's suffix link before the
// node and edge writes. Rejected and ignored symbols go straight to the result.
// Throughput: one item at a time; the next item is taken in the cycle after the result loads.
// Reset: asynchronous, control state only; the roots are constants, so no clearing pass runs.
module palindromic_tree_insert_core #(
  parameter int unsigned MAX_LEN  = pti_pkg::MAX_LEN_DEF,
  parameter int unsigned ALPHABET = pti_pkg::ALPHABET_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] symbol, [7:5] zero
  input  logic [pti_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [12:0] suffix_palindromes, [25:13] longest_length, [38:26] node_index,
  // [39] created, [52:40] occurrences, [55:53] zero
  output logic [pti_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] full_res
  output logic                           m_axis_tuser
);
  import pti_pkg::*;

  // Node indexes reach MAX_LEN+1; lengths and counts reach MAX_LEN.
  localparam int unsigned NW = $clog2(MAX_LEN + 2);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = LW + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WNODE, ST_WTEXT, ST_ERD, ST_EVFY, ST_SCNT, ST_DONE
  } state_e;

  state_e st_q, st_d;

  logic [SYM_W-1:0] sym_q, sym_d;
  logic [LW-1:0] text_len_q, text_len_d;
  logic [NW-1:0] last_q, last_d, total_q, total_d;
  logic [NW-1:0] v_q, v_d, p_q, p_d, linkp_q, linkp_d, linkv_q, linkv_d;
  logic [NW-1:0] c_q, c_d, link_cur_q, link_cur_d;
  logic signed [LW:0] lenp_q, lenp_d, lenv_q, lenv_d;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic walk2_q, walk2_d;

  // Result waiting to be moved into the output register.
  logic [FIELD_W-1:0] r_sp_q, r_sp_d, r_len_q, r_len_d, r_node_q, r_node_d;
  logic [FIELD_W-1:0] r_occ_q, r_occ_d;
  logic r_created_q, r_created_d, r_full_q, r_full_d;

  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic m_valid_q, m_valid_d, m_user_q, m_user_d;

  // Node memory port signals.
  logic [NW-1:0] nd_rd_addr;
  logic signed [LW:0] nd_len;
  logic [NW-1:0] nd_link, nd_parent;
  logic [LW-1:0] nd_scnt, nd_occ;
  logic [SYM_W-1:0] nd_sym;
  logic nd_we;
  logic [NW-1:0] nd_wa, nd_wlink, nd_wparent;
  logic [LW-1:0] nd_wlen, nd_wscnt, nd_wocc;

  // Edge memory port signals.
  logic [NW-1:0] ed_node, ed_wdata, ed_rdata;
  logic ed_we;

  // Text store: positions 1..text length; position 0 is never used.
  logic [SYM_W-1:0] text_mem [MAX_LEN + 1];
  logic [SYM_W-1:0] text_rd_q;
  logic [LW-1:0] text_ra, text_wa;
  logic text_we;

  logic signed [PW-1:0] pos;
  logic exists;
  logic [LW-1:0] scnt_new;
  logic [NW-1:0] cur;

  pti_node_mem #(.NW(NW), .LW(LW)) u_node_mem (
    .clk_i       (clk_i),
    .rd_addr_i   (nd_rd_addr),
    .rd_len_o    (nd_len),
    .rd_link_o   (nd_link),
    .rd_scnt_o   (nd_scnt),
    .rd_occ_o    (nd_occ),
    .rd_parent_o (nd_parent),
    .rd_sym_o    (nd_sym),
    .wr_en_i     (nd_we),
    .wr_addr_i   (nd_wa),
    .wr_len_i    (nd_wlen),
    .wr_link_i   (nd_wlink),
    .wr_scnt_i   (nd_wscnt),
    .wr_occ_i    (nd_wocc),
    .wr_parent_i (nd_wparent),
    .wr_sym_i    (sym_q)
  );

  pti_edge_mem #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET), .NW(NW)) u_edge_mem (
    .clk_i     (clk_i),
    .node_i    (ed_node),
    .sym_i     (sym_q),
    .wr_en_i   (ed_we),
    .wr_data_i (ed_wdata),
    .rd_data_o (ed_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_wa] <= s_axis_tdata[SYM_W-1:0];
    end
    text_rd_q <= text_mem[text_ra];
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Mirror position of the node under test, in the text as it now stands.
  assign pos = $signed({2'b00, text_len_q}) - PW'(nd_len) - PW'(1);

  // An edge entry is trusted only if the node it names exists and was created
  // from this very parent and symbol. Stale entries from before reset, or
  // from rows never cleared, fail that check, so the edge memory needs no sweep.
  assign exists = (c_q >= NW'(2)) && (c_q <= total_q) &&
                  (nd_parent == v_q) && (nd_sym == sym_q);

  assign scnt_new = nd_scnt + LW'(1);
  assign cur      = total_q + NW'(1);

  always_comb begin
    st_d = st_q;
    sym_d = sym_q;
    text_len_d = text_len_q;
    last_d = last_q;
    total_d = total_q;
    v_d = v_q;
    p_d = p_q;
    linkp_d = linkp_q;
    linkv_d = linkv_q;
    lenp_d = lenp_q;
    lenv_d = lenv_q;
    c_d = c_q;
    link_cur_d = link_cur_q;
    cur_len_d = cur_len_q;
    walk2_d = walk2_q;
    r_sp_d = r_sp_q;
    r_len_d = r_len_q;
    r_node_d = r_node_q;
    r_occ_d = r_occ_q;
    r_created_d = r_created_q;
    r_full_d = r_full_q;
    m_data_d = m_data_q;
    m_user_d = m_user_q;
    m_valid_d = m_valid_q & ~m_axis_tready;

    nd_rd_addr = v_q;
    nd_we = 1'b0;
    nd_wa = c_q;
    nd_wlen = nd_len[LW-1:0];
    nd_wlink = nd_link;
    nd_wscnt = nd_scnt;
    nd_wocc = nd_occ + LW'(1);
    nd_wparent = nd_parent;
    ed_node = v_q;
    ed_we = 1'b0;
    ed_wdata = cur;
    text_we = 1'b0;
    text_wa = text_len_q + LW'(1);
    text_ra = pos[LW-1:0];

    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d = s_axis_tdata[SYM_W-1:0];
          r_sp_d = '0;
          r_len_d = '0;
          r_node_d = '0;
          r_occ_d = '0;
          r_created_d = 1'b0;
          r_full_d = 1'b0;
          if ({4'b0000, s_axis_tdata[SYM_W-1:0]} >= 9'(ALPHABET)) begin
            st_d = ST_DONE;
          end else if (text_len_q == LW'(MAX_LEN)) begin
            r_full_d = 1'b1;
            st_d = ST_DONE;
          end else begin
            text_we = 1'b1;
            text_len_d = text_len_q + LW'(1);
            v_d = last_q;
            nd_rd_addr = last_q;
            walk2_d = 1'b0;
            st_d = ST_WNODE;
          end
        end
      end
      ST_WNODE: begin
        if (nd_len < 0) begin
          // The odd root always matches: its mirror is the new symbol itself.
          if (!walk2_q) begin
            p_d = v_q;
            lenp_d = nd_len;
            linkp_d = nd_link;
          end
          st_d = ST_ERD;
        end else if (pos < PW'(1)) begin
          // Mirror falls on the sentinel: move on along the suffix link.
          v_d = nd_link;
          nd_rd_addr = nd_link;
        end else begin
          linkv_d = nd_link;
          lenv_d = nd_len;
          st_d = ST_WTEXT;
        end
      end
      ST_WTEXT: begin
        if (text_rd_q == sym_q) begin
          if (!walk2_q) begin
            p_d = v_q;
            lenp_d = lenv_q;
            linkp_d = linkv_q;
          end
          st_d = ST_ERD;
        end else begin
          v_d = linkv_q;
          nd_rd_addr = linkv_q;
          st_d = ST_WNODE;
        end
      end
      ST_ERD: begin
        c_d = ed_rdata;
        nd_rd_addr = ed_rdata;
        st_d = ST_EVFY;
      end
      ST_EVFY: begin
        if (!walk2_q) begin
          if (exists) begin
            // Known palindrome: bump its raw count in place.
            nd_we = 1'b1;
            last_d = c_q;
            r_sp_d = FIELD_W'(nd_scnt);
            r_len_d = FIELD_W'(nd_len[LW-1:0]);
            r_node_d = FIELD_W'(c_q);
            r_occ_d = FIELD_W'(nd_wocc);
            st_d = ST_DONE;
          end else begin
            walk2_d = 1'b1;
            cur_len_d = LW'(lenp_q + (LW+1)'(2));
            v_d = linkp_q;
            nd_rd_addr = linkp_q;
            st_d = ST_WNODE;
          end
        end else begin
          link_cur_d = exists ? c_q : '0;
          nd_rd_addr = exists ? c_q : '0;
          st_d = ST_SCNT;
        end
      end
      ST_SCNT: begin
        nd_we = 1'b1;
        nd_wa = cur;
        nd_wlen = cur_len_q;
        nd_wlink = link_cur_q;
        nd_wscnt = scnt_new;
        nd_wocc = LW'(1);
        nd_wparent = p_q;
        ed_node = p_q;
        ed_we = 1'b1;
        total_d = cur;
        last_d = cur;
        r_sp_d = FIELD_W'(scnt_new);
        r_len_d = FIELD_W'(cur_len_q);
        r_node_d = FIELD_W'(cur);
        r_occ_d = FIELD_W'(1);
        r_created_d = 1'b1;
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d = {3'b000, r_occ_q, r_created_q, r_node_q, r_len_q, r_sp_q};
          m_user_d = r_full_q;
          m_valid_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      text_len_q <= '0;
      last_q <= '0;
      total_q <= NW'(1);
      walk2_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      text_len_q <= text_len_d;
      last_q <= last_d;
      total_q <= total_d;
      walk2_q <= walk2_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    v_q <= v_d;
    p_q <= p_d;
    linkp_q <= linkp_d;
    linkv_q <= linkv_d;
    lenp_q <= lenp_d;
    lenv_q <= lenv_d;
    c_q <= c_d;
    link_cur_q <= link_cur_d;
    cur_len_q <= cur_len_d;
    r_sp_q <= r_sp_d;
    r_len_q <= r_len_d;
    r_node_q <= r_node_d;
    r_occ_q <= r_occ_d;
    r_created_q <= r_created_d;
    r_full_q <= r_full_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= NW'(MAX_LEN + 1))
    else $error("node count beyond capacity");

  a_text_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_len_q != $past(text_len_q)) |-> (text_len_q == $past(text_len_q) + LW'(1)))
    else $error("text length moved by more than one");

  a_nodes_vs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NW+1)'(total_q) <= (NW+1)'(text_len_q) + (NW+1)'(1))
    else $error("more nodes than text positions");

  a_create_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCNT) |-> (cur_len_q != '0))
    else $error("new node with zero length");
`endif

endmodule

@@ sim/palindromic_tree_insert_core_tb.sv @@
`timescale 1ns / 1ps

module palindromic_tree_insert_core_tb;

  localparam int unsigned MAX_LEN  = pti_pkg::MAX_LEN_DEF;
  localparam int unsigned ALPHABET = pti_pkg::ALPHABET_DEF;
  localparam int unsigned NODES    = MAX_LEN + 2;

  typedef struct packed {
    logic        full_res;
    logic [12:0] occurrences;
    logic        created;
    logic [12:0] node_index;
    logic [12:0] longest_length;
    logic [12:0] suffix_palindromes;
  } tree_result_t;

  // Mirror of the tree and a queue of the results it predicts.
  class tree_scoreboard;
    int unsigned  text_chars [MAX_LEN+1];
    int           node_len   [NODES];
    int unsigned  link_of    [NODES];
    int unsigned  child      [NODES*ALPHABET];
    int unsigned  pal_count  [NODES];
    int unsigned  end_count  [NODES];
    int unsigned  top_node, prev_node, text_len;
    tree_result_t awaited [$];
    int unsigned  errors, checked, made_nodes, rejected, ignored;

    function new();
      node_len[0] = 0;  node_len[1] = -1;
      link_of[0]  = 1;  link_of[1]  = 0;
      pal_count[0] = 0; pal_count[1] = 0;
      end_count[0] = 0; end_count[1] = 0;
      for (int i = 0; i < 2 * ALPHABET; i++) child[i] = 0;
      text_chars[0] = 31;
      top_node = 1; prev_node = 0; text_len = 0;
    endfunction

    // Climb suffix links until the character mirrored across node v equals sym.
    function int unsigned find_mirror(int unsigned v, int unsigned sym);
      int pos;
      forever begin
        pos = int'(text_len) - node_len[v] - 1;
        if (pos >= 1 && pos <= int'(text_len) && text_chars[pos] == sym) return v;
        if (node_len[v] < 0) return v;
        v = link_of[v];
      end
    endfunction

    function void note_symbol(logic [4:0] sym);
      tree_result_t r;
      int unsigned  p, q, cur, nd;
      r = '0;
      if (sym >= ALPHABET) begin
        ignored++;
      end else if (text_len >= MAX_LEN) begin
        r.full_res = 1'b1;
        rejected++;
      end else begin
        text_len++;
        text_chars[text_len] = 32'(sym);
        p = find_mirror(prev_node, 32'(sym));
        if (child[p*ALPHABET+sym] == 0) begin
          cur = top_node + 1;
          for (int i = 0; i < ALPHABET; i++) child[cur*ALPHABET+i] = 0;
          node_len[cur] = node_len[p] + 2;
          q = find_mirror(link_of[p], 32'(sym));
          link_of[cur] = child[q*ALPHABET+sym];
          child[p*ALPHABET+sym] = cur;
          pal_count[cur] = pal_count[link_of[cur]] + 1;
          end_count[cur] = 0;
          top_node = cur;
          r.created = 1'b1;
          made_nodes++;
        end
        nd = child[p*ALPHABET+sym];
        prev_node = nd;
        end_count[nd]++;
        r.suffix_palindromes = 13'(pal_count[nd]);
        r.longest_length     = 13'(node_len[nd]);
        r.node_index         = 13'(nd);
        r.occurrences        = 13'(end_count[nd]);
      end
      awaited.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task check_result(tree_result_t got);
      tree_result_t exp;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = awaited.pop_front();
      if (got.suffix_palindromes !== exp.suffix_palindromes)
        report($sformatf("result %0d suffix_palindromes %0d, want %0d", checked,
                         got.suffix_palindromes, exp.suffix_palindromes));
      if (got.longest_length !== exp.longest_length)
        report($sformatf("result %0d longest_length %0d, want %0d", checked,
                         got.longest_length, exp.longest_length));
      if (got.node_index !== exp.node_index)
        report($sformatf("result %0d node_index %0d, want %0d", checked,
                         got.node_index, exp.node_index));
      if (got.created !== exp.created)
        report($sformatf("result %0d created %b, want %b", checked,
                         got.created, exp.created));
      if (got.occurrences !== exp.occurrences)
        report($sformatf("result %0d occurrences %0d, want %0d", checked,
                         got.occurrences, exp.occurrences));
      if (got.full_res !== exp.full_res)
        report($sformatf("result %0d full_res %b, want %b", checked,
                         got.full_res, exp.full_res));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pti_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pti_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;

  tree_scoreboard tree_sb = new();
  bit             no_gaps = 1'b0;
  int unsigned    symbols_sent = 0;

  palindromic_tree_insert_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random except inside the gap-free stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tree_sb.check_result({m_axis_tuser, m_axis_tdata[52:0]});
  end

  // Offer one symbol, with an occasional random gap, and note it once it is taken.
  task send_symbol(logic [4:0] sym);
    while (!no_gaps && $urandom_range(99) < 24) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    tree_sb.note_symbol(sym);
    symbols_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task drain_results();
    while (tree_sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned run_len, span, base;
    logic [4:0]  run_buf [64];
    logic [4:0]  directed [20];
    logic [4:0]  tail [5];
    bit          drained;
    directed = '{5'd0, 5'd0, 5'd0, 5'd25, 5'd0, 5'd0, 5'd26, 5'd31, 5'd1, 5'd0, 5'd1,
                 5'd25, 5'd1, 5'd0, 5'd1, 5'd0, 5'd25, 5'd25, 5'd30, 5'd0};
    tail     = '{5'd0, 5'd25, 5'd31, 5'd1, 5'd26};
    drained  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, ignored symbols, repeats and nested palindromes.
    for (int i = 0; i < 20; i++) send_symbol(directed[i]);

    // Random: mostly mirrored runs over small alphabets, plus plain text and noise.
    while (symbols_sent < 825) begin
      no_gaps = (symbols_sent >= 350 && symbols_sent < 500);
      if (!drained && symbols_sent >= 600) begin
        drain_results();
        drained = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          run_len = $urandom_range(1, 12);
          span    = $urandom_range(1, 4);
          base    = $urandom_range(0, ALPHABET - span);
          for (int i = 0; i < run_len; i++) begin
            run_buf[i] = 5'(base + $urandom_range(span - 1));
            send_symbol(run_buf[i]);
          end
          if ($urandom_range(1)) send_symbol(5'(base + $urandom_range(span - 1)));
          for (int i = run_len - 1; i >= 0; i--) send_symbol(run_buf[i]);
        end
        6, 7, 8: begin
          span = $urandom_range(1) ? 2 : ALPHABET;
          repeat ($urandom_range(1, 10)) send_symbol(5'($urandom_range(span - 1)));
        end
        default: send_symbol(5'($urandom_range(31)));
      endcase
    end
    no_gaps = 1'b0;

    // A short mixed tail of valid and out-of-range symbols.
    for (int i = 0; i < 5; i++) send_symbol(tail[i]);

    drain_results();
    repeat (100) @(negedge clk_i);
    $display("Ran %0d symbols: %0d new nodes, %0d rejected as full, %0d ignored.",
             symbols_sent, tree_sb.made_nodes, tree_sb.rejected, tree_sb.ignored);
    $display("Stored text grew to %0d symbols across runs, noise and stalls.",
             tree_sb.text_len);
    if (tree_sb.errors == 0 && tree_sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out waiting for results.");
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pti_pkg.sv
rtl/pti_node_mem.sv
rtl/pti_edge_mem.sv
rtl/palindromic_tree_insert_core.sv
sim/palindromic_tree_insert_core_tb.sv
